// ===== rtl/rpn_pkg.sv =====
package rpn_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int MAG_W  = 48;
  localparam int CNT_W  = 6;

  // Input kind codes
  localparam logic [2:0] KIND_PUSH    = 3'd0;
  localparam logic [2:0] KIND_ADD     = 3'd1;
  localparam logic [2:0] KIND_SUB     = 3'd2;
  localparam logic [2:0] KIND_MUL     = 3'd3;
  localparam logic [2:0] KIND_DIV     = 3'd4;
  localparam logic [2:0] KIND_REM     = 3'd5;
  localparam logic [2:0] KIND_SHOW    = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  // Step counts of the shift-add / shift-subtract unit
  localparam logic [CNT_W-1:0] STEPS_MUL = 6'd32;
  localparam logic [CNT_W-1:0] STEPS_DIV = 6'd48;
  localparam logic [CNT_W-1:0] STEPS_REM = 6'd16;

  localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic {
    ITER_MUL,
    ITER_DIV
  } iter_mode_t;

  typedef struct packed {
    logic               start;
    iter_mode_t         mode;
    logic [CNT_W-1:0]   count;
    logic [MAG_W-1:0]   dvd;
    logic [WORD_W-1:0]  m;
  } iter_req_t;

  typedef struct packed {
    logic busy;
  } iter_stat_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [WORD_W-1:0] wdata;
  } stack_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

  function automatic logic [WORD_W-1:0] abs_mag(input logic [WORD_W-1:0] v);
    abs_mag = v[WORD_W-1] ? (~v + 32'd1) : v;
  endfunction

  // Signed value from sign and magnitude, clipped to the 32-bit range
  function automatic logic [WORD_W-1:0] sat_mag(input logic neg,
                                                input logic [MAG_W-1:0] mag);
    logic [WORD_W-1:0] low;
    low = mag[WORD_W-1:0];
    if (!neg) begin
      sat_mag = (mag > {16'd0, SAT_MAX}) ? SAT_MAX : low;
    end else begin
      sat_mag = (mag > {16'd0, SAT_MIN}) ? SAT_MIN : (~low + 32'd1);
    end
  endfunction

  function automatic logic [WORD_W-1:0] sat_sum(input logic [WORD_W:0] s);
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_sum = s[WORD_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_sum = s[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/rpn_in_if.sv =====
interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink (input valid, input kind, input operand, output ready);
endinterface

// ===== rtl/rpn_out_if.sv =====
interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] shown_value;
  logic               shown;
  logic               empty_error;
  logic               full_error;
  logic               zero_divisor;
  logic               unknown_command;

  modport source (output valid, output shown_value, output shown, output empty_error,
                  output full_error, output zero_divisor, output unknown_command,
                  input ready);
  modport sink (input valid, input shown_value, input shown, input empty_error,
                input full_error, input zero_divisor, input unknown_command,
                output ready);
endinterface

// ===== rtl/rpn_iter.sv =====
module rpn_iter (
  input  logic                               clk,
  input  logic                               rst,
  input  rpn_pkg::iter_req_t                 req,
  output rpn_pkg::iter_stat_t                stat,
  output logic [rpn_pkg::MAG_W-1:0]          quo,
  output logic [rpn_pkg::WORD_W-1:0]         part
);

  logic                             busy;
  rpn_pkg::iter_mode_t              mode;
  logic [rpn_pkg::CNT_W-1:0]        cnt;
  logic [rpn_pkg::WORD_W:0]         acc;
  logic [rpn_pkg::MAG_W-1:0]        q;
  logic [rpn_pkg::WORD_W-1:0]       m;
  logic [rpn_pkg::WORD_W:0]         mul_sum;
  logic [rpn_pkg::WORD_W:0]         shifted;
  logic [rpn_pkg::WORD_W+1:0]       diff;

  always_comb begin
    mul_sum = {1'b0, acc[rpn_pkg::WORD_W-1:0]} + (q[0] ? {1'b0, m} : 33'd0);
    shifted = {acc[rpn_pkg::WORD_W-1:0], q[rpn_pkg::MAG_W-1]};
    diff    = {1'b0, shifted} - {2'b00, m};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      mode <= req.mode;
      cnt  <= req.count;
      acc  <= '0;
      q    <= req.dvd;
      m    <= req.m;
    end else if (busy) begin
      unique case (mode)
        rpn_pkg::ITER_MUL: begin
          // shift the partial product right, multiplier bits leave at the bottom
          acc <= {1'b0, mul_sum[rpn_pkg::WORD_W:1]};
          q   <= {16'd0, mul_sum[0], q[rpn_pkg::WORD_W-1:1]};
        end
        rpn_pkg::ITER_DIV: begin
          if (!diff[rpn_pkg::WORD_W+1]) begin
            acc <= diff[rpn_pkg::WORD_W:0];
            q   <= {q[rpn_pkg::MAG_W-2:0], 1'b1};
          end else begin
            acc <= shifted;
            q   <= {q[rpn_pkg::MAG_W-2:0], 1'b0};
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign quo       = q;
  assign part      = acc[rpn_pkg::WORD_W-1:0];

endmodule

// ===== rtl/rpn_stack.sv =====
module rpn_stack #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpn_pkg::stack_cmd_t           cmd,
  output rpn_pkg::stack_stat_t          stat,
  output logic [rpn_pkg::WORD_W-1:0]    rd_data
);

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [rpn_pkg::WORD_W-1:0] mem [STACK_DEPTH];
  logic [SPW-1:0]             sp;
  logic [SPW-1:0]             sp_dec;

  assign sp_dec     = sp - SPW'(1);
  assign stat.empty = (sp == '0);
  assign stat.full  = (sp == SPW'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.push && !stat.full) begin
      sp <= sp + SPW'(1);
    end else if (cmd.pop && !stat.empty) begin
      sp <= sp_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !stat.full) begin
      mem[sp[AW-1:0]] <= cmd.wdata;
    end
    if (cmd.pop && !stat.empty) begin
      rd_data <= mem[sp_dec[AW-1:0]];
    end
  end

endmodule

// ===== rtl/rpn_stack_calculator_unit.sv =====
// Reverse Polish calculator on Q16.16 signed values with a value stack of
// STACK_DEPTH entries. Each command gives one result transfer. The shared
// shift-add / shift-subtract unit retires one product or quotient bit per
// cycle, and each stack pop goes through the stack memory's registered read.
// A new command is taken in the idle state after the previous one is
// finished; a result waiting on the output does not hold off the next
// command, but that command's result waits until the earlier one has left.
module rpn_stack_calculator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  rpn_in_if.sink    cmd,
  rpn_out_if.source res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_GET_B,
    S_POP_A,
    S_GET_A,
    S_RUN,
    S_PUSH,
    S_FINISH
  } state_t;

  state_t                       state;
  logic [2:0]                   kind;
  logic [rpn_pkg::WORD_W-1:0]   operand;
  logic [rpn_pkg::WORD_W-1:0]   b;
  logic [rpn_pkg::WORD_W-1:0]   push_val;
  logic [rpn_pkg::WORD_W-1:0]   shown_val;
  logic                         hit;
  logic                         neg;
  logic                         f_shown;
  logic                         f_empty;
  logic                         f_full;
  logic                         f_zdiv;
  logic                         f_unk;

  rpn_pkg::stack_cmd_t          st_cmd;
  rpn_pkg::stack_stat_t         st_stat;
  logic [rpn_pkg::WORD_W-1:0]   rd_data;
  rpn_pkg::iter_req_t           it_req;
  rpn_pkg::iter_stat_t          it_stat;
  logic [rpn_pkg::MAG_W-1:0]    it_quo;
  logic [rpn_pkg::WORD_W-1:0]   it_part;

  logic [rpn_pkg::WORD_W-1:0]   popped;
  logic [rpn_pkg::WORD_W-1:0]   pop_mag;
  logic [rpn_pkg::WORD_W-1:0]   b_mag;
  logic [rpn_pkg::WORD_W:0]     addsub;
  logic [rpn_pkg::MAG_W-1:0]    run_mag;

  rpn_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (st_cmd),
    .stat    (st_stat),
    .rd_data (rd_data)
  );

  rpn_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .req  (it_req),
    .stat (it_stat),
    .quo  (it_quo),
    .part (it_part)
  );

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    // an empty pop reads as zero
    popped  = hit ? rd_data : '0;
    pop_mag = rpn_pkg::abs_mag(popped);
    b_mag   = rpn_pkg::abs_mag(b);
    if (kind == rpn_pkg::KIND_SUB) begin
      addsub = {popped[rpn_pkg::WORD_W-1], popped} - {b[rpn_pkg::WORD_W-1], b};
    end else begin
      addsub = {popped[rpn_pkg::WORD_W-1], popped} + {b[rpn_pkg::WORD_W-1], b};
    end
  end

  always_comb begin
    st_cmd.push  = (state == S_PUSH);
    st_cmd.pop   = ((state == S_POP_B) || (state == S_POP_A)) && !st_stat.empty;
    st_cmd.wdata = (kind == rpn_pkg::KIND_PUSH) ? operand : push_val;
  end

  always_comb begin
    it_req.start = (state == S_GET_A) &&
                   ((kind == rpn_pkg::KIND_MUL) || (kind == rpn_pkg::KIND_DIV) ||
                    (kind == rpn_pkg::KIND_REM));
    it_req.mode  = rpn_pkg::ITER_DIV;
    it_req.count = rpn_pkg::STEPS_DIV;
    it_req.dvd   = {pop_mag, 16'd0};
    it_req.m     = b_mag;
    unique case (kind)
      rpn_pkg::KIND_MUL: begin
        it_req.mode  = rpn_pkg::ITER_MUL;
        it_req.count = rpn_pkg::STEPS_MUL;
        it_req.dvd   = {16'd0, pop_mag};
      end
      rpn_pkg::KIND_REM: begin
        // integer parts only
        it_req.count = rpn_pkg::STEPS_REM;
        it_req.dvd   = {pop_mag[rpn_pkg::WORD_W-1:rpn_pkg::FRAC_W], 32'd0};
        it_req.m     = {16'd0, b_mag[rpn_pkg::WORD_W-1:rpn_pkg::FRAC_W]};
      end
      default: begin
        it_req.mode = rpn_pkg::ITER_DIV;
      end
    endcase
  end

  always_comb begin
    unique case (kind)
      rpn_pkg::KIND_MUL: run_mag = {it_part, it_quo[rpn_pkg::WORD_W-1:rpn_pkg::FRAC_W]};
      rpn_pkg::KIND_REM: run_mag = {16'd0, it_part[rpn_pkg::FRAC_W-1:0], 16'd0};
      default:           run_mag = it_quo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != S_FINISH)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            kind      <= cmd.kind;
            operand   <= cmd.operand;
            shown_val <= '0;
            f_shown   <= 1'b0;
            f_empty   <= 1'b0;
            f_full    <= 1'b0;
            f_zdiv    <= 1'b0;
            f_unk     <= 1'b0;
            if (cmd.kind == rpn_pkg::KIND_PUSH) begin
              state <= S_PUSH;
            end else if (cmd.kind == rpn_pkg::KIND_UNKNOWN) begin
              f_unk <= 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_POP_B;
            end
          end
        end
        S_POP_B: begin
          hit <= !st_stat.empty;
          if (st_stat.empty) begin
            f_empty <= 1'b1;
          end
          state <= S_GET_B;
        end
        S_GET_B: begin
          b <= popped;
          priority if (kind == rpn_pkg::KIND_SHOW) begin
            shown_val <= popped;
            f_shown   <= 1'b1;
            state     <= S_FINISH;
          end else if ((kind == rpn_pkg::KIND_DIV) && (popped == '0)) begin
            f_zdiv <= 1'b1;
            state  <= S_FINISH;
          end else if ((kind == rpn_pkg::KIND_REM) &&
                       (pop_mag[rpn_pkg::WORD_W-1:rpn_pkg::FRAC_W] == '0)) begin
            f_zdiv <= 1'b1;
            state  <= S_FINISH;
          end else begin
            state <= S_POP_A;
          end
        end
        S_POP_A: begin
          hit <= !st_stat.empty;
          if (st_stat.empty) begin
            f_empty <= 1'b1;
          end
          state <= S_GET_A;
        end
        S_GET_A: begin
          neg <= (kind == rpn_pkg::KIND_REM) ? popped[rpn_pkg::WORD_W-1]
                                             : (popped[rpn_pkg::WORD_W-1] ^
                                                b[rpn_pkg::WORD_W-1]);
          if ((kind == rpn_pkg::KIND_ADD) || (kind == rpn_pkg::KIND_SUB)) begin
            push_val <= rpn_pkg::sat_sum(addsub);
            state    <= S_PUSH;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!it_stat.busy) begin
            push_val <= rpn_pkg::sat_mag(neg, run_mag);
            state    <= S_PUSH;
          end
        end
        S_PUSH: begin
          if ((kind == rpn_pkg::KIND_PUSH) && st_stat.full) begin
            f_full <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!res.valid || res.ready) begin
            res.valid           <= 1'b1;
            res.shown_value     <= shown_val;
            res.shown           <= f_shown;
            res.empty_error     <= f_empty;
            res.full_error      <= f_full;
            res.zero_divisor    <= f_zdiv;
            res.unknown_command <= f_unk;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/rpn_result_checker.sv =====
`timescale 1ns / 100ps

module rpn_result_checker #(
  parameter int STACK_DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  rpn_in_if    cmd_mon,
  rpn_out_if   res_mon,
  output int   mismatches,
  output int   awaiting
);

  typedef struct {
    logic signed [31:0] shown_value;
    logic               shown;
    logic               empty_error;
    logic               full_error;
    logic               zero_divisor;
    logic               unknown_command;
  } calc_result_t;

  logic signed [31:0] held_values [STACK_DEPTH];
  int                 held_count;
  calc_result_t       expected_results [$];

  function automatic logic signed [31:0] clip(input longint v);
    if (v > 64'sd2147483647) return rpn_pkg::SAT_MAX;
    if (v < -64'sd2147483648) return rpn_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic push_held(input logic signed [31:0] v);
    if (held_count < STACK_DEPTH) begin
      held_values[held_count] = v;
      held_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // An empty pop reads as zero and flags the command
  function automatic logic signed [31:0] pop_held(inout logic empty_seen);
    if (held_count > 0) begin
      held_count--;
      return held_values[held_count];
    end
    empty_seen = 1'b1;
    return '0;
  endfunction

  function automatic calc_result_t evaluate_command(input logic [2:0] kind,
                                                    input logic signed [31:0] operand);
    calc_result_t       r;
    logic               empty_seen;
    logic signed [31:0] a;
    logic signed [31:0] b;
    longint             ia;
    longint             ib;
    r = '{shown_value: '0, default: 1'b0};
    empty_seen = 1'b0;
    case (kind)
      rpn_pkg::KIND_PUSH: begin
        r.full_error = !push_held(operand);
      end
      rpn_pkg::KIND_ADD: begin
        b = pop_held(empty_seen);
        a = pop_held(empty_seen);
        void'(push_held(clip(longint'(a) + longint'(b))));
      end
      rpn_pkg::KIND_SUB: begin
        b = pop_held(empty_seen);
        a = pop_held(empty_seen);
        void'(push_held(clip(longint'(a) - longint'(b))));
      end
      rpn_pkg::KIND_MUL: begin
        b = pop_held(empty_seen);
        a = pop_held(empty_seen);
        void'(push_held(clip((longint'(a) * longint'(b)) / 65536)));
      end
      rpn_pkg::KIND_DIV: begin
        b = pop_held(empty_seen);
        if (b == 0) begin
          r.zero_divisor = 1'b1;
        end else begin
          a = pop_held(empty_seen);
          void'(push_held(clip((longint'(a) * 65536) / longint'(b))));
        end
      end
      rpn_pkg::KIND_REM: begin
        // both operands drop their fractions before the remainder
        b = pop_held(empty_seen);
        ib = longint'(b) / 65536;
        if (ib == 0) begin
          r.zero_divisor = 1'b1;
        end else begin
          a = pop_held(empty_seen);
          ia = longint'(a) / 65536;
          void'(push_held(clip((ia % ib) * 65536)));
        end
      end
      rpn_pkg::KIND_SHOW: begin
        r.shown_value = pop_held(empty_seen);
        r.shown = 1'b1;
      end
      default: begin
        r.unknown_command = 1'b1;
      end
    endcase
    r.empty_error = empty_seen;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    calc_result_t want;
    if (rst) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("shown_value", want.shown_value, res_mon.shown_value);
          check_field("shown", want.shown, res_mon.shown);
          check_field("empty_error", want.empty_error, res_mon.empty_error);
          check_field("full_error", want.full_error, res_mon.full_error);
          check_field("zero_divisor", want.zero_divisor, res_mon.zero_divisor);
          check_field("unknown_command", want.unknown_command, res_mon.unknown_command);
        end
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        expected_results.push_back(evaluate_command(cmd_mon.kind, cmd_mon.operand));
      end
    end
    awaiting = expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int STACK_DEPTH     = 128;
  localparam int RANDOM_COMMANDS = 600;

  logic clk;
  logic rst;
  logic gaps_on;
  int   mismatches;
  int   awaiting;
  int   commands_sent;

  rpn_in_if  cmd_ch ();
  rpn_out_if res_ch ();

  rpn_stack_calculator_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  rpn_result_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cmd_mon(cmd_ch),
    .res_mon(res_ch),
    .mismatches(mismatches),
    .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, with occasional stretches of none
  initial begin
    int   stall;
    logic quiet;
    quiet = 1'b0;
    res_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_command(input logic [2:0] kind, input logic [31:0] operand);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.kind    <= kind;
    cmd_ch.operand <= operand;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    @(negedge clk);
    commands_sent++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return {16'($urandom_range(0, 40) - 20), 16'h0000};
      1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      2: return '0;
      3: begin
        case ($urandom_range(0, 3))
          0: return rpn_pkg::SAT_MAX;
          1: return rpn_pkg::SAT_MIN;
          2: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_binary();
    case ($urandom_range(0, 4))
      0: return rpn_pkg::KIND_ADD;
      1: return rpn_pkg::KIND_SUB;
      2: return rpn_pkg::KIND_MUL;
      3: return rpn_pkg::KIND_DIV;
      default: return rpn_pkg::KIND_REM;
    endcase
  endfunction

  task automatic run_expression();
    int leaves;
    int pushed;
    int depth;
    leaves = $urandom_range(1, 6);
    pushed = 0;
    depth = 0;
    while (pushed < leaves || depth > 1) begin
      if (pushed < leaves && (depth < 2 || $urandom_range(0, 1) == 1)) begin
        send_command(rpn_pkg::KIND_PUSH, pick_operand());
        pushed++;
        depth++;
      end else begin
        send_command(pick_binary(), $urandom);
        depth--;
      end
    end
    send_command(rpn_pkg::KIND_SHOW, $urandom);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(5, 20)) send_command(3'($urandom_range(0, 7)), $urandom);
  endtask

  // Overflow the stack, then drain it through arithmetic and shows
  task automatic run_fill();
    repeat (STACK_DEPTH + $urandom_range(2, 8)) begin
      send_command(rpn_pkg::KIND_PUSH, pick_operand());
    end
    repeat (STACK_DEPTH + 4) begin
      if ($urandom_range(0, 3) == 0) send_command(rpn_pkg::KIND_SHOW, $urandom);
      else send_command(pick_binary(), $urandom);
    end
  endtask

  initial begin
    int   directed_end;
    logic fill_done;
    rst = 1'b1;
    gaps_on = 1'b1;
    commands_sent = 0;
    fill_done = 1'b0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.kind    <= rpn_pkg::KIND_PUSH;
    cmd_ch.operand <= '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_command(rpn_pkg::KIND_SHOW, 32'h0000_0000);
    send_command(rpn_pkg::KIND_ADD, 32'h0000_0000);
    send_command(rpn_pkg::KIND_DIV, 32'h0000_0000);
    send_command(rpn_pkg::KIND_REM, 32'h0000_0000);
    send_command(rpn_pkg::KIND_UNKNOWN, 32'hFFFF_FFFF);
    send_command(rpn_pkg::KIND_PUSH, rpn_pkg::SAT_MIN);
    send_command(rpn_pkg::KIND_PUSH, 32'h0000_0001);
    send_command(rpn_pkg::KIND_SUB, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, rpn_pkg::SAT_MIN);
    send_command(rpn_pkg::KIND_MUL, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, 32'h0000_8000);
    send_command(rpn_pkg::KIND_DIV, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, 32'hFFFF_0000);
    send_command(rpn_pkg::KIND_DIV, 32'h0000_0000);
    send_command(rpn_pkg::KIND_SHOW, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, rpn_pkg::SAT_MIN);
    send_command(rpn_pkg::KIND_PUSH, 32'hFFFF_0000);
    send_command(rpn_pkg::KIND_DIV, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, 32'hFFF9_0000);
    send_command(rpn_pkg::KIND_PUSH, 32'hFFFD_C000);
    send_command(rpn_pkg::KIND_REM, 32'h0000_0000);
    send_command(rpn_pkg::KIND_PUSH, 32'h0000_8000);
    send_command(rpn_pkg::KIND_REM, 32'h0000_0000);
    send_command(rpn_pkg::KIND_ADD, 32'h0000_0000);
    send_command(rpn_pkg::KIND_SHOW, 32'h0000_0000);
    settle();
    directed_end = commands_sent;

    while (commands_sent < directed_end + RANDOM_COMMANDS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (!fill_done && commands_sent > directed_end + 150) begin
        run_fill();
        settle();
        fill_done = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        run_noise();
      end else begin
        run_expression();
      end
      if ($urandom_range(0, 15) == 0) settle();
    end

    settle();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
